// File: sv/assert_macros.svh
// assertion macros shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define BFEA_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("allocator check failed");

// consequent holds in the cycle after the antecedent
`define BFEA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// File: sv/bfea_pkg.sv
// shared types and constants of the best-fit extent allocator
`default_nettype none
package bfea_pkg;

    localparam int MAX_EXTENTS = 64;
    localparam int IDX_W = $clog2(MAX_EXTENTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int ADDR_W = 24;
    localparam int SIZE_W = ADDR_W + 1;
    localparam int END_W = SIZE_W + 1;
    localparam logic [SIZE_W-1:0] RESET_TOTAL = SIZE_W'(1) << ADDR_W;
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_EXTENTS);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_IGNORED = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_WRITE_RM,
        OP_RM,
        OP_APPEND
    } op_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
        logic rm_read;
        logic rm_write;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_issued;
        logic rd_pending;
        logic need_remove;
        logic rm_trivial;
        logic out_busy;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: sv/bfea_req_if.sv
// request and response channel interfaces
`default_nettype none
interface bfea_req_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [bfea_pkg::SIZE_W-1:0]     block_count;
    logic [bfea_pkg::ADDR_W-1:0]     block_start;
    modport source (output valid, action, block_count, block_start, input ready);
    modport sink (input valid, action, block_count, block_start, output ready);
endinterface

interface bfea_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [bfea_pkg::ADDR_W-1:0]     granted_start;
    logic [bfea_pkg::SIZE_W-1:0]     granted_count;
    logic [bfea_pkg::SIZE_W-1:0]     free_elements;
    modport source (output valid, status, granted_start, granted_count, free_elements,
                    input ready);
    modport sink (input valid, status, granted_start, granted_count, free_elements,
                  output ready);
endinterface
`default_nettype wire

// File: sv/bfea_ctrl.sv
// controller state machine of the allocator
`default_nettype none
`include "assert_macros.svh"
module bfea_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bfea_pkg::dp_stat_t stat,
    output bfea_pkg::dp_cmd_t       cmd
);
    import bfea_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_RM_RD  = 6'b001000,
        S_RM_WR  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!stat.scan_issued)
                begin
                    cmd.scan = 1'b1;
                end
                else if (!stat.rd_pending)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.commit = 1'b1;
                state_next = stat.need_remove ? S_RM_RD : S_FINISH;
            end
            S_RM_RD:
            begin
                cmd.rm_read = 1'b1;
                state_next = stat.rm_trivial ? S_FINISH : S_RM_WR;
            end
            S_RM_WR:
            begin
                cmd.rm_write = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `BFEA_ASSERT_NEXT(a_remove_follows, cmd.commit && stat.need_remove, state_reg == S_RM_RD)
    `BFEA_ASSERT_ALWAYS(a_ready_only_idle, !in_ready || state_reg == S_IDLE)

endmodule
`default_nettype wire

// File: sv/bfea_dp.sv
// extent table, scan trackers and result registers of the allocator
`default_nettype none
`include "assert_macros.svh"
module bfea_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [bfea_pkg::SIZE_W-1:0] cfg_wdata,
    input  wire bfea_pkg::dp_cmd_t           cmd,
    output bfea_pkg::dp_stat_t               stat,
    input  wire logic                        action,
    input  wire logic [bfea_pkg::SIZE_W-1:0] block_count,
    input  wire logic [bfea_pkg::ADDR_W-1:0] block_start,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [1:0]                       status,
    output logic [bfea_pkg::ADDR_W-1:0]      granted_start,
    output logic [bfea_pkg::SIZE_W-1:0]      granted_count,
    output logic [bfea_pkg::SIZE_W-1:0]      free_elements
);
    import bfea_pkg::*;

    logic [ADDR_W+SIZE_W-1:0] mem [MAX_EXTENTS];

    logic [SIZE_W-1:0] total_reg;
    logic [SIZE_W-1:0] free_total_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              init_flag_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              rd_valid_reg;
    logic              rd_init_reg;
    logic [IDX_W-1:0]  eval_idx_reg;
    logic [ADDR_W+SIZE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rm_target_reg;
    logic              out_valid_reg;

    logic              act_reg;
    logic [SIZE_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] st_reg;

    logic              best_found_reg, after_found_reg, before_found_reg, overlap_reg;
    logic [IDX_W-1:0]  best_idx_reg, after_idx_reg, before_idx_reg;
    logic [ADDR_W-1:0] best_start_reg, before_start_reg;
    logic [SIZE_W-1:0] best_size_reg, after_size_reg, before_size_reg;

    logic [1:0]        res_status_reg;
    logic [ADDR_W-1:0] res_gstart_reg;
    logic [SIZE_W-1:0] res_gcount_reg;
    logic [1:0]        out_status_reg;
    logic [ADDR_W-1:0] out_gstart_reg;
    logic [SIZE_W-1:0] out_gcount_reg;
    logic [SIZE_W-1:0] out_free_reg;

    logic [SIZE_W-1:0] cfg_clamped;
    logic [ADDR_W-1:0] e_start;
    logic [SIZE_W-1:0] e_size;
    logic [END_W-1:0]  e_end;
    logic [END_W-1:0]  req_end;
    logic              fits, better, ov, is_after, is_before;

    op_t               op;
    status_t           dec_status;
    logic [IDX_W-1:0]  wr_idx;
    logic [ADDR_W-1:0] wr_start;
    logic [SIZE_W-1:0] wr_size;
    logic [IDX_W-1:0]  rm_idx;
    logic [END_W-1:0]  gstart_wide;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [ADDR_W+SIZE_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
    logic              re;

    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_clamped = SIZE_W'(1);
        end
        else if (cfg_wdata > RESET_TOTAL)
        begin
            cfg_clamped = RESET_TOTAL;
        end
        else
        begin
            cfg_clamped = cfg_wdata;
        end
    end

    // entry view with the power-on extent folded in
    assign e_start = rd_init_reg ? '0 : rd_data_reg[ADDR_W+SIZE_W-1:SIZE_W];
    assign e_size = rd_init_reg ? total_reg : rd_data_reg[SIZE_W-1:0];
    assign e_end = END_W'(e_start) + END_W'(e_size);
    assign req_end = END_W'(st_reg) + END_W'(cnt_reg);

    assign fits = e_size >= cnt_reg;
    assign better = !best_found_reg || e_size < best_size_reg ||
                    (e_size == best_size_reg && e_start < best_start_reg);
    assign ov = END_W'(st_reg) < e_end && END_W'(e_start) < req_end;
    assign is_after = END_W'(e_start) == req_end;
    assign is_before = e_end == END_W'(st_reg);

    assign gstart_wide = END_W'(best_start_reg) + END_W'(best_size_reg) - END_W'(cnt_reg);

    always_comb
    begin
        op = OP_NONE;
        dec_status = ST_OK;
        wr_idx = '0;
        wr_start = '0;
        wr_size = '0;
        rm_idx = '0;
        if (cnt_reg == '0)
        begin
            dec_status = ST_IGNORED;
        end
        else if (!act_reg)
        begin
            if (!best_found_reg)
            begin
                dec_status = ST_OOM;
            end
            else if (best_size_reg == cnt_reg)
            begin
                op = OP_RM;
                rm_idx = best_idx_reg;
            end
            else
            begin
                op = OP_WRITE;
                wr_idx = best_idx_reg;
                wr_start = best_start_reg;
                wr_size = best_size_reg - cnt_reg;
            end
        end
        else if (req_end > END_W'(total_reg) || overlap_reg)
        begin
            dec_status = ST_IGNORED;
        end
        else if (after_found_reg && before_found_reg)
        begin
            op = OP_WRITE_RM;
            wr_idx = before_idx_reg;
            wr_start = before_start_reg;
            wr_size = before_size_reg + cnt_reg + after_size_reg;
            rm_idx = after_idx_reg;
        end
        else if (before_found_reg)
        begin
            op = OP_WRITE;
            wr_idx = before_idx_reg;
            wr_start = before_start_reg;
            wr_size = before_size_reg + cnt_reg;
        end
        else if (after_found_reg)
        begin
            op = OP_WRITE;
            wr_idx = after_idx_reg;
            wr_start = st_reg;
            wr_size = after_size_reg + cnt_reg;
        end
        else if (count_reg >= MAX_COUNT)
        begin
            dec_status = ST_FULL;
        end
        else
        begin
            op = OP_APPEND;
            wr_idx = count_reg[IDX_W-1:0];
            wr_start = st_reg;
            wr_size = cnt_reg;
        end
    end

    always_comb
    begin
        we = 1'b0;
        waddr = wr_idx;
        wdata = {wr_start, wr_size};
        if (cmd.commit && op != OP_NONE && op != OP_RM)
        begin
            we = 1'b1;
        end
        else if (cmd.rm_write)
        begin
            we = 1'b1;
            waddr = rm_target_reg;
            wdata = {e_start, e_size};
        end
        re = cmd.scan || cmd.rm_read;
        raddr = cmd.scan ? idx_reg[IDX_W-1:0] : count_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= RESET_TOTAL;
            free_total_reg <= RESET_TOTAL;
            count_reg <= CNT_W'(1);
            init_flag_reg <= 1'b1;
            idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            rd_init_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan;
            if (re)
            begin
                rd_init_reg <= raddr == '0 && init_flag_reg;
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (we && waddr == '0)
            begin
                init_flag_reg <= 1'b0;
            end
            if (cmd.commit)
            begin
                if (op == OP_RM || op == OP_WRITE_RM)
                begin
                    count_reg <= count_reg - CNT_W'(1);
                end
                else if (op == OP_APPEND)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (dec_status == ST_OK && cnt_reg != '0)
                begin
                    free_total_reg <= act_reg ? free_total_reg + cnt_reg
                                              : free_total_reg - cnt_reg;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                total_reg <= cfg_clamped;
                free_total_reg <= cfg_clamped;
                count_reg <= CNT_W'(1);
                init_flag_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= raddr;
        if (cmd.load)
        begin
            act_reg <= action;
            cnt_reg <= block_count;
            st_reg <= block_start;
            best_found_reg <= 1'b0;
            after_found_reg <= 1'b0;
            before_found_reg <= 1'b0;
            overlap_reg <= 1'b0;
        end
        else if (rd_valid_reg)
        begin
            if (fits && better)
            begin
                best_found_reg <= 1'b1;
                best_idx_reg <= eval_idx_reg;
                best_start_reg <= e_start;
                best_size_reg <= e_size;
            end
            if (ov)
            begin
                overlap_reg <= 1'b1;
            end
            if (is_after)
            begin
                after_found_reg <= 1'b1;
                after_idx_reg <= eval_idx_reg;
                after_size_reg <= e_size;
            end
            if (is_before)
            begin
                before_found_reg <= 1'b1;
                before_idx_reg <= eval_idx_reg;
                before_start_reg <= e_start;
                before_size_reg <= e_size;
            end
        end
        if (cmd.commit)
        begin
            rm_target_reg <= rm_idx;
            res_status_reg <= dec_status;
            res_gstart_reg <= (!act_reg && dec_status == ST_OK && cnt_reg != '0)
                              ? gstart_wide[ADDR_W-1:0] : '0;
            res_gcount_reg <= (!act_reg && dec_status == ST_OK) ? cnt_reg : '0;
        end
        if (cmd.finish)
        begin
            out_status_reg <= res_status_reg;
            out_gstart_reg <= res_gstart_reg;
            out_gcount_reg <= res_gcount_reg;
            out_free_reg <= free_total_reg;
        end
    end

    assign stat.scan_issued = idx_reg == count_reg;
    assign stat.rd_pending = rd_valid_reg;
    assign stat.need_remove = op == OP_RM || op == OP_WRITE_RM;
    assign stat.rm_trivial = CNT_W'(rm_target_reg) == count_reg;
    assign stat.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign status = out_status_reg;
    assign granted_start = out_gstart_reg;
    assign granted_count = out_gcount_reg;
    assign free_elements = out_free_reg;

    `BFEA_ASSERT_ALWAYS(a_count_bound, count_reg <= MAX_COUNT)
    `BFEA_ASSERT_ALWAYS(a_free_bound, free_total_reg <= total_reg)

endmodule
`default_nettype wire

// File: sv/best_fit_extent_allocator.sv
// top level of the best-fit extent allocator
//
//  channel  dir  handshake      contents
//  req      in   valid/ready    action, block_count, block_start
//  rsp      out  valid/ready    status, granted_start, granted_count, free_elements
//  cfg      in   cfg_we         total_elements
//
// a transaction runs from accept through the table scan, the decision and the finish state;
// the table scan reads one entry a cycle from the extent memory
// a removal adds S_RM_RD, and S_RM_WR when the last entry moves into the freed slot
// reset and a cfg write restore one free extent at once, no clearing pass
// a new request is taken while the previous response still waits on rsp.ready
`default_nettype none
module best_fit_extent_allocator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [bfea_pkg::SIZE_W-1:0] cfg_wdata,
    bfea_req_if.sink                         req,
    bfea_rsp_if.source                       rsp
);
    import bfea_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;
    logic     out_valid;

    bfea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfea_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .stat          (stat),
        .action        (req.action),
        .block_count   (req.block_count),
        .block_start   (req.block_start),
        .out_valid     (out_valid),
        .out_ready     (rsp.ready),
        .status        (rsp.status),
        .granted_start (rsp.granted_start),
        .granted_count (rsp.granted_count),
        .free_elements (rsp.free_elements)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

endmodule
`default_nettype wire
